### design/box_overlap_detection_scorer_top_defines.svh
// assertion macros shared by the scorer modules
// expects signals named clock and reset in the scope of each use
`ifndef BOX_OVERLAP_DETECTION_SCORER_TOP_DEFINES_SVH
`define BOX_OVERLAP_DETECTION_SCORER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BODS_ASSERT_HOLDS(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication, checked outside reset
`define BODS_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

### design/bods_pkg.sv
// shared types and constants of the box overlap scorer
// no dependencies
package bods_pkg;

   // fixed field widths of the channels
   localparam int FIELD_BITS = 16;
   localparam int OUT_BITS   = 32;
   localparam int THR_BITS   = 17;
   localparam int FRAC_BITS  = 16;

   // default sizes handed down from the top level
   localparam int COORD_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF = 32;

   // threshold after reset: 0.5
   localparam logic [THR_BITS-1:0] THR_RESET = 17'h08000;

   typedef enum logic [1:0] {
      OUT_TN = 2'd0,
      OUT_FP = 2'd1,
      OUT_FN = 2'd2,
      OUT_TP = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INTER,
      SEQ_ENCL,
      SEQ_SCALE,
      SEQ_DECIDE
   } seq_state_type;

   // decision handed from the sequencer to the counters
   typedef struct packed {
      logic        valid;
      outcome_type outcome;
   } tally_cmd_type;

endpackage

### design/bods_if.sv
// channel interfaces: box pair input, score result and threshold write
// depends on bods_pkg
interface bods_req_if;
   import bods_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  truth_present;
   logic [FIELD_BITS-1:0] truth_x_min;
   logic [FIELD_BITS-1:0] truth_y_min;
   logic [FIELD_BITS-1:0] truth_x_max;
   logic [FIELD_BITS-1:0] truth_y_max;
   logic                  det_present;
   logic [FIELD_BITS-1:0] det_x_min;
   logic [FIELD_BITS-1:0] det_y_min;
   logic [FIELD_BITS-1:0] det_x_max;
   logic [FIELD_BITS-1:0] det_y_max;

   modport source (output valid, truth_present, truth_x_min, truth_y_min, truth_x_max,
                   truth_y_max, det_present, det_x_min, det_y_min, det_x_max, det_y_max,
                   input ready);
   modport sink (input valid, truth_present, truth_x_min, truth_y_min, truth_x_max,
                 truth_y_max, det_present, det_x_min, det_y_min, det_x_max, det_y_max,
                 output ready);
endinterface

interface bods_rsp_if;
   import bods_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          outcome;
   logic [OUT_BITS-1:0] tp_total;
   logic [OUT_BITS-1:0] fp_total;
   logic [OUT_BITS-1:0] tn_total;
   logic [OUT_BITS-1:0] fn_total;

   modport source (output valid, outcome, tp_total, fp_total, tn_total, fn_total,
                   input ready);
   modport sink (input valid, outcome, tp_total, fp_total, tn_total, fn_total,
                 output ready);
endinterface

interface bods_csr_if;
   import bods_pkg::*;
   logic                valid;
   logic                ready;
   logic [THR_BITS-1:0] overlap_threshold;

   modport source (output valid, overlap_threshold, input ready);
   modport sink (input valid, overlap_threshold, output ready);
endinterface

### design/box_overlap_detection_scorer_top.sv
// top level of the box overlap scorer
// depends on bods_pkg, bods_if, bods_mul, bods_seq, bods_tally
//
// channel    port        dir  moves
// input      req_chan    in   one box pair item
// result     rsp_chan    out  outcome and four totals per item
// threshold  csr_chan    in   overlap threshold write
//
// a pair of present, overlapping boxes goes from acceptance to result through
// span capture, three products through the one shared multiplier, decision;
// any other item goes from span capture straight to the decision.
// reset clears the counters and loads a threshold of 0.5; there is no clearing pass.
// a result waits in its register while the next item is taken; that item's
// decision then waits until the result has been taken.
module box_overlap_detection_scorer_top #(
   parameter int COORD_BITS = bods_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = bods_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   bods_req_if.sink    req_chan,
   bods_rsp_if.source  rsp_chan,
   bods_csr_if.sink    csr_chan
);
   import bods_pkg::*;

   localparam int CW   = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int AREA = 2 * CW;

   logic                     mul_en;
   logic [THR_BITS-1:0]      mul_a;
   logic [AREA-1:0]          mul_b;
   logic [THR_BITS+AREA-1:0] mul_p;
   tally_cmd_type            cmd;
   logic                     cmd_ready;

   // shared multiplier
   bods_mul #(
      .A_BITS(THR_BITS),
      .B_BITS(AREA)
   ) u_mul (
      .clock(clock),
      .en   (mul_en),
      .a    (mul_a),
      .b    (mul_b),
      .p_ff (mul_p)
   );

   // sequencer
   bods_seq #(
      .COORD_BITS(COORD_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .csr      (csr_chan),
      .mul_en   (mul_en),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_p    (mul_p),
      .cmd      (cmd),
      .cmd_ready(cmd_ready)
   );

   // counters and result register
   bods_tally #(
      .COUNT_BITS(COUNT_BITS)
   ) u_tally (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cmd_ready(cmd_ready),
      .rsp      (rsp_chan)
   );

endmodule

### design/bods_mul.sv
// shared unsigned multiplier with registered product
// no dependencies beyond its parameters
module bods_mul #(
   parameter int A_BITS = 17,
   parameter int B_BITS = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [A_BITS-1:0]        a,
   input  logic [B_BITS-1:0]        b,
   output logic [A_BITS+B_BITS-1:0] p_ff
);

   logic [A_BITS+B_BITS-1:0] p_in;

   // one product per enabled cycle
   assign p_in = (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

endmodule

### design/bods_seq.sv
// sequencer: takes box pairs, forms spans, drives the shared multiplier, decides
// depends on bods_pkg, bods_if, the defines header
module bods_seq #(
   parameter int COORD_BITS = bods_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   bods_req_if.sink               req,
   bods_csr_if.sink               csr,
   output logic                   mul_en,
   output logic [bods_pkg::THR_BITS-1:0] mul_a,
   output logic [2*((COORD_BITS < bods_pkg::FIELD_BITS) ? COORD_BITS
                  : bods_pkg::FIELD_BITS)-1:0] mul_b,
   input  logic [bods_pkg::THR_BITS+2*((COORD_BITS < bods_pkg::FIELD_BITS) ? COORD_BITS
                  : bods_pkg::FIELD_BITS)-1:0] mul_p,
   output bods_pkg::tally_cmd_type cmd,
   input  logic                   cmd_ready
);
   import bods_pkg::*;
   `include "box_overlap_detection_scorer_top_defines.svh"

   localparam int CW       = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int AREA     = 2 * CW;
   localparam int CMP_BITS = THR_BITS + AREA;

   seq_state_type       state_ff, state_in;
   logic [THR_BITS-1:0] thr_ff;
   logic [CW-1:0]       isx_ff, isy_ff, esx_ff, esy_ff;
   logic [CW-1:0]       isx_in, isy_in, esx_in, esy_in;
   logic [AREA-1:0]     inter_ff;
   logic                ratio_ff, ratio_in;
   outcome_type         fixed_ff, fixed_in;
   logic                load_spans;

   logic [CW-1:0] tx0, ty0, tx1, ty1, dx0, dy0, dx1, dy1;
   logic [CW-1:0] ix0, iy0, ix1, iy1, ex0, ey0, ex1, ey1;
   logic          overlap;
   logic          met;

   // coordinates in their low bits
   assign tx0 = req.truth_x_min[CW-1:0];
   assign ty0 = req.truth_y_min[CW-1:0];
   assign tx1 = req.truth_x_max[CW-1:0];
   assign ty1 = req.truth_y_max[CW-1:0];
   assign dx0 = req.det_x_min[CW-1:0];
   assign dy0 = req.det_y_min[CW-1:0];
   assign dx1 = req.det_x_max[CW-1:0];
   assign dy1 = req.det_y_max[CW-1:0];

   // intersection and enclosing box edges
   assign ix0 = (tx0 > dx0) ? tx0 : dx0;
   assign iy0 = (ty0 > dy0) ? ty0 : dy0;
   assign ix1 = (tx1 < dx1) ? tx1 : dx1;
   assign iy1 = (ty1 < dy1) ? ty1 : dy1;
   assign ex0 = (tx0 < dx0) ? tx0 : dx0;
   assign ey0 = (ty0 < dy0) ? ty0 : dy0;
   assign ex1 = (tx1 > dx1) ? tx1 : dx1;
   assign ey1 = (ty1 > dy1) ? ty1 : dy1;

   assign overlap = (ix1 > ix0) && (iy1 > iy0);
   assign isx_in  = ix1 - ix0;
   assign isy_in  = iy1 - iy0;
   assign esx_in  = ex1 - ex0;
   assign esy_in  = ey1 - ey0;

   // inter * 2^16 against threshold * enclosing area
   assign met = CMP_BITS'({inter_ff, {FRAC_BITS{1'b0}}}) >= CMP_BITS'(mul_p);

   // threshold register, always writable
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr.valid) begin
         thr_ff <= csr.overlap_threshold;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-item payload
   always_ff @(posedge clock) begin
      if (load_spans) begin
         isx_ff   <= isx_in;
         isy_ff   <= isy_in;
         esx_ff   <= esx_in;
         esy_ff   <= esy_in;
         ratio_ff <= ratio_in;
         fixed_ff <= fixed_in;
      end
      if (state_ff == SEQ_ENCL) begin
         inter_ff <= mul_p[AREA-1:0];
      end
   end

   // next state, multiplier operands and decision
   always_comb begin
      state_in    = state_ff;
      req.ready   = 1'b0;
      load_spans  = 1'b0;
      ratio_in    = 1'b0;
      fixed_in    = OUT_FP;
      mul_en      = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      cmd.valid   = 1'b0;
      cmd.outcome = fixed_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            req.ready  = 1'b1;
            load_spans = req.valid;
            priority if (!req.truth_present && !req.det_present) begin
               fixed_in = OUT_TN;
            end else if (!req.truth_present) begin
               fixed_in = OUT_FP;
            end else if (!req.det_present) begin
               fixed_in = OUT_FN;
            end else begin
               fixed_in = OUT_FP;
               ratio_in = overlap;
            end
            if (req.valid) begin
               state_in = ratio_in ? SEQ_INTER : SEQ_DECIDE;
            end
         end
         SEQ_INTER: begin
            mul_en   = 1'b1;
            mul_a    = THR_BITS'(isx_ff);
            mul_b    = AREA'(isy_ff);
            state_in = SEQ_ENCL;
         end
         SEQ_ENCL: begin
            mul_en   = 1'b1;
            mul_a    = THR_BITS'(esx_ff);
            mul_b    = AREA'(esy_ff);
            state_in = SEQ_SCALE;
         end
         SEQ_SCALE: begin
            mul_en   = 1'b1;
            mul_a    = thr_ff;
            mul_b    = mul_p[AREA-1:0];
            state_in = SEQ_DECIDE;
         end
         SEQ_DECIDE: begin
            cmd.valid = 1'b1;
            if (ratio_ff) begin
               cmd.outcome = met ? OUT_TP : OUT_FP;
            end
            if (cmd_ready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // a taken decision frees the sequencer
   `BODS_ASSERT_NEXT(a_done_idle, cmd.valid && cmd_ready, state_ff == SEQ_IDLE, "decision taken but sequencer busy")
   // a true positive needs a nonzero intersection
   `BODS_ASSERT_HOLDS(a_tp_area, cmd.valid && cmd.outcome == OUT_TP, inter_ff != '0, "true positive with empty intersection")
   // an item with no truth box skips the multiplier
   `BODS_ASSERT_NEXT(a_no_truth, req.valid && req.ready && !req.truth_present, state_ff == SEQ_DECIDE, "absent truth went through the multiplier")

endmodule

### design/bods_tally.sv
// saturating outcome counters and the result register
// depends on bods_pkg, bods_if, the defines header
module bods_tally #(
   parameter int COUNT_BITS = bods_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bods_pkg::tally_cmd_type cmd,
   output logic                    cmd_ready,
   bods_rsp_if.source              rsp
);
   import bods_pkg::*;
   `include "box_overlap_detection_scorer_top_defines.svh"

   logic [COUNT_BITS-1:0] tp_ff, fp_ff, tn_ff, fn_ff;
   logic [COUNT_BITS-1:0] tp_in, fp_in, tn_in, fn_in;
   logic                  valid_ff, valid_in;
   outcome_type           outcome_ff;
   logic                  take;

   // result slot free or being emptied
   assign cmd_ready = !valid_ff || rsp.ready;
   assign take      = cmd.valid && cmd_ready;

   // bump the counter named by the outcome, holding at all ones
   always_comb begin
      tp_in = tp_ff;
      fp_in = fp_ff;
      tn_in = tn_ff;
      fn_in = fn_ff;
      if (take) begin
         unique case (cmd.outcome)
            OUT_TP:  tp_in = (tp_ff == '1) ? tp_ff : tp_ff + COUNT_BITS'(1);
            OUT_FP:  fp_in = (fp_ff == '1) ? fp_ff : fp_ff + COUNT_BITS'(1);
            OUT_TN:  tn_in = (tn_ff == '1) ? tn_ff : tn_ff + COUNT_BITS'(1);
            OUT_FN:  fn_in = (fn_ff == '1) ? fn_ff : fn_ff + COUNT_BITS'(1);
            default: tp_in = tp_ff;
         endcase
      end
   end

   assign valid_in = take || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff    <= '0;
         fp_ff    <= '0;
         tn_ff    <= '0;
         fn_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         tp_ff    <= tp_in;
         fp_ff    <= fp_in;
         tn_ff    <= tn_in;
         fn_ff    <= fn_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         outcome_ff <= cmd.outcome;
      end
   end

   // result fields, counters change only when a new item is loaded
   assign rsp.valid    = valid_ff;
   assign rsp.outcome  = outcome_ff;
   assign rsp.tp_total = OUT_BITS'(tp_ff);
   assign rsp.fp_total = OUT_BITS'(fp_ff);
   assign rsp.tn_total = OUT_BITS'(tn_ff);
   assign rsp.fn_total = OUT_BITS'(fn_ff);

   // counters never move without a decision
   `BODS_ASSERT_NEXT(a_hold, !take, $stable({tp_ff, fp_ff, tn_ff, fn_ff}), "counter moved idle")
   // counters never go down
   `BODS_ASSERT_NEXT(a_up_pos, 1'b1, tp_ff >= $past(tp_ff) && fp_ff >= $past(fp_ff), "count fell")
   `BODS_ASSERT_NEXT(a_up_neg, 1'b1, tn_ff >= $past(tn_ff) && fn_ff >= $past(fn_ff), "count fell")
   // a shown true negative is already counted
   `BODS_ASSERT_HOLDS(a_tn_count, valid_ff && outcome_ff == OUT_TN, tn_ff != '0, "tn not counted")

endmodule

### tb/tb_box_overlap_detection_scorer_top.sv
`timescale 1ns / 100ps
// self-checking testbench for box_overlap_detection_scorer_top: a directed table of box pairs,
// then random pairs over several thresholds and idling patterns; needs bods_pkg, bods_if, rtl

module tb_box_overlap_detection_scorer_top;
   import bods_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 75;
   localparam int PHASES       = 6;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 20;
   localparam int PRINT_CAP    = 40;
   localparam logic [THR_BITS-1:0] THR_ONE = 17'h10000;
   localparam logic [THR_BITS-1:0] THR_TOP = 17'h1FFFF;

   typedef struct packed {
      logic                  truth_present;
      logic [FIELD_BITS-1:0] truth_x_min;
      logic [FIELD_BITS-1:0] truth_y_min;
      logic [FIELD_BITS-1:0] truth_x_max;
      logic [FIELD_BITS-1:0] truth_y_max;
      logic                  det_present;
      logic [FIELD_BITS-1:0] det_x_min;
      logic [FIELD_BITS-1:0] det_y_min;
      logic [FIELD_BITS-1:0] det_x_max;
      logic [FIELD_BITS-1:0] det_y_max;
   } box_pair_type;

   typedef struct packed {
      outcome_type         outcome;
      logic [OUT_BITS-1:0] tp;
      logic [OUT_BITS-1:0] fp;
      logic [OUT_BITS-1:0] tn;
      logic [OUT_BITS-1:0] fn;
   } score_type;

   typedef struct {
      logic                set_thr;
      logic [THR_BITS-1:0] thr;
      box_pair_type        pair;
      logic                typed;
      score_type           want;
   } step_row_type;

   logic clock;
   logic reset;

   bods_req_if req_if ();
   bods_rsp_if rsp_if ();
   bods_csr_if csr_if ();

   box_overlap_detection_scorer_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // scorer state as the testbench sees it
   logic [THR_BITS-1:0] model_thr;
   logic [OUT_BITS-1:0] tp_count, fp_count, tn_count, fn_count;
   score_type           score_q[$];
   step_row_type        steps[$];

   int   errors;
   int   thr_writes;
   int   results_seen;
   int   cycles_run;
   int   send_idle_pct;
   int   recv_stall_pct;
   logic long_hold_go;

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // run limit
   initial begin
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("tb_box_overlap_detection_scorer_top: errors");
      $finish;
   end

   task automatic report_error(input string what);
      if (errors < PRINT_CAP)
         $display("%0t ns  mismatch: %s", $time, what);
      errors++;
   endtask

   task automatic check_total(input string label, input logic [OUT_BITS-1:0] got,
                              input logic [OUT_BITS-1:0] want);
      if (got !== want)
         report_error($sformatf("%s total %0d, want %0d", label, got, want));
   endtask

   function automatic logic [OUT_BITS-1:0] bump(input logic [OUT_BITS-1:0] c);
      return (&c) ? c : c + OUT_BITS'(1);
   endfunction

   // score one pair: exact ratio test, inter * 2^16 against thr * enclosing area
   function automatic outcome_type grade_pair(input box_pair_type p,
                                              input logic [THR_BITS-1:0] thr);
      logic [63:0] ix0, ix1, iy0, iy1, ex0, ex1, ey0, ey1, inter, encl;
      if (!p.truth_present)
         return p.det_present ? OUT_FP : OUT_TN;
      if (!p.det_present)
         return OUT_FN;
      ix0 = 64'((p.truth_x_min > p.det_x_min) ? p.truth_x_min : p.det_x_min);
      ix1 = 64'((p.truth_x_max < p.det_x_max) ? p.truth_x_max : p.det_x_max);
      iy0 = 64'((p.truth_y_min > p.det_y_min) ? p.truth_y_min : p.det_y_min);
      iy1 = 64'((p.truth_y_max < p.det_y_max) ? p.truth_y_max : p.det_y_max);
      if (ix1 <= ix0 || iy1 <= iy0)
         return OUT_FP;
      ex0 = 64'((p.truth_x_min < p.det_x_min) ? p.truth_x_min : p.det_x_min);
      ex1 = 64'((p.truth_x_max > p.det_x_max) ? p.truth_x_max : p.det_x_max);
      ey0 = 64'((p.truth_y_min < p.det_y_min) ? p.truth_y_min : p.det_y_min);
      ey1 = 64'((p.truth_y_max > p.det_y_max) ? p.truth_y_max : p.det_y_max);
      inter = (ix1 - ix0) * (iy1 - iy0);
      encl  = (ex1 - ex0) * (ey1 - ey0);
      return ((inter << FRAC_BITS) >= 64'(thr) * encl) ? OUT_TP : OUT_FP;
   endfunction

   function automatic box_pair_type boxes(input int tp, tx0, ty0, tx1, ty1,
                                          input int dp, dx0, dy0, dx1, dy1);
      box_pair_type p;
      p.truth_present = (tp != 0);
      p.truth_x_min   = tx0[FIELD_BITS-1:0];
      p.truth_y_min   = ty0[FIELD_BITS-1:0];
      p.truth_x_max   = tx1[FIELD_BITS-1:0];
      p.truth_y_max   = ty1[FIELD_BITS-1:0];
      p.det_present   = (dp != 0);
      p.det_x_min     = dx0[FIELD_BITS-1:0];
      p.det_y_min     = dy0[FIELD_BITS-1:0];
      p.det_x_max     = dx1[FIELD_BITS-1:0];
      p.det_y_max     = dy1[FIELD_BITS-1:0];
      return p;
   endfunction

   function automatic score_type totals(input outcome_type oc, input int tp, fp, tn, fn);
      score_type s;
      s.outcome = oc;
      s.tp      = tp;
      s.fp      = fp;
      s.tn      = tn;
      s.fn      = fn;
      return s;
   endfunction

   task automatic add_row(input int set_thr, input logic [THR_BITS-1:0] thr,
                          input box_pair_type pair);
      step_row_type r;
      r.set_thr = (set_thr != 0);
      r.thr     = thr;
      r.pair    = pair;
      r.typed   = 1'b0;
      r.want    = totals(OUT_TN, 0, 0, 0, 0);
      steps     = {steps, r};
   endtask

   task automatic add_typed(input box_pair_type pair, input score_type want);
      step_row_type r;
      r.set_thr = 1'b0;
      r.thr     = '0;
      r.pair    = pair;
      r.typed   = 1'b1;
      r.want    = want;
      steps     = {steps, r};
   endtask

   function automatic logic [FIELD_BITS-1:0] clamp_coord(input int v);
      if (v < 0)
         return '0;
      if (v > 65535)
         return '1;
      return v[FIELD_BITS-1:0];
   endfunction

   function automatic int jitter(input int w);
      return int'($urandom_range(w)) - w / 2;
   endfunction

   // random pair: mostly present, overlapping boxes near the threshold, the rest noise
   function automatic box_pair_type rand_pair();
      box_pair_type p;
      int        sel, shape, w, h, x, y;
      logic [FIELD_BITS-1:0] tmp;
      p.truth_x_min = FIELD_BITS'($urandom);
      p.truth_y_min = FIELD_BITS'($urandom);
      p.truth_x_max = FIELD_BITS'($urandom);
      p.truth_y_max = FIELD_BITS'($urandom);
      p.det_x_min   = FIELD_BITS'($urandom);
      p.det_y_min   = FIELD_BITS'($urandom);
      p.det_x_max   = FIELD_BITS'($urandom);
      p.det_y_max   = FIELD_BITS'($urandom);
      sel = $urandom_range(99);
      p.truth_present = (sel >= 16);
      p.det_present   = (sel >= 8 && sel < 16) || sel >= 24;
      if (sel >= 24) begin
         shape = $urandom_range(99);
         w = ($urandom_range(9) == 0) ? $urandom_range(30000, 1) : $urandom_range(64, 1);
         h = ($urandom_range(9) == 0) ? $urandom_range(30000, 1) : $urandom_range(64, 1);
         x = $urandom_range(65535 - w);
         y = $urandom_range(65535 - h);
         if (shape < 75 && shape >= 60) begin
            // fully random edges, reversed ones included
         end else if (shape >= 75 && shape < 85) begin
            // boxes crowded into the far corner
            p.truth_x_max = '1;
            p.truth_y_max = '1;
            p.truth_x_min = FIELD_BITS'(65535 - $urandom_range(200));
            p.truth_y_min = FIELD_BITS'(65535 - $urandom_range(200));
            p.det_x_max   = FIELD_BITS'(65535 - $urandom_range(3));
            p.det_y_max   = '1;
            p.det_x_min   = FIELD_BITS'(65535 - $urandom_range(200));
            p.det_y_min   = FIELD_BITS'(65535 - $urandom_range(200));
         end else begin
            p.truth_x_min = FIELD_BITS'(x);
            p.truth_x_max = FIELD_BITS'(x + w);
            p.truth_y_min = FIELD_BITS'(y);
            p.truth_y_max = FIELD_BITS'(y + h);
            p.det_x_min   = clamp_coord(x + jitter(w));
            p.det_x_max   = clamp_coord(x + w + jitter(w));
            p.det_y_min   = clamp_coord(y + jitter(h));
            p.det_y_max   = clamp_coord(y + h + jitter(h));
            if (shape >= 85 && shape < 93) begin
               // detection touching the right edge of the truth
               p.det_x_min = p.truth_x_max;
               p.det_x_max = clamp_coord(x + 2 * w);
            end else if (shape >= 93) begin
               // truth with swapped edges in one axis
               if ($urandom_range(1)) begin
                  tmp = p.truth_x_min;
                  p.truth_x_min = p.truth_x_max;
                  p.truth_x_max = tmp;
               end else begin
                  tmp = p.truth_y_min;
                  p.truth_y_min = p.truth_y_max;
                  p.truth_y_max = tmp;
               end
            end
         end
      end
      return p;
   endfunction

   // offer one pair, then predict its score once it is taken
   task automatic offer_pair(input box_pair_type p, input logic typed, input score_type want);
      score_type s;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.truth_present <= p.truth_present;
      req_if.truth_x_min   <= p.truth_x_min;
      req_if.truth_y_min   <= p.truth_y_min;
      req_if.truth_x_max   <= p.truth_x_max;
      req_if.truth_y_max   <= p.truth_y_max;
      req_if.det_present   <= p.det_present;
      req_if.det_x_min     <= p.det_x_min;
      req_if.det_y_min     <= p.det_y_min;
      req_if.det_x_max     <= p.det_x_max;
      req_if.det_y_max     <= p.det_y_max;
      req_if.valid         <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      s.outcome = grade_pair(p, model_thr);
      case (s.outcome)
         OUT_TN:  tn_count = bump(tn_count);
         OUT_FP:  fp_count = bump(fp_count);
         OUT_FN:  fn_count = bump(fn_count);
         default: tp_count = bump(tp_count);
      endcase
      s.tp = tp_count;
      s.fp = fp_count;
      s.tn = tn_count;
      s.fn = fn_count;
      if (typed)
         s = want;
      score_q = {score_q, s};
   endtask

   // stop offering and wait for every pending score
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (score_q.size() != 0);
   endtask

   task automatic write_threshold(input logic [THR_BITS-1:0] value);
      settle();
      csr_if.overlap_threshold <= value;
      csr_if.valid             <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      model_thr = value;
      thr_writes++;
      csr_if.valid <= 1'b0;
   endtask

   // result side: random stalls, plus one long hold-off counted here
   initial begin
      int   hold_left;
      logic hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // compare each score taken with the oldest one pending
   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (score_q.size() == 0) begin
            report_error("score arrived with nothing pending");
         end else begin
            want = score_q.pop_front();
            if (rsp_if.outcome !== want.outcome)
               report_error($sformatf("outcome %0d, want %s", rsp_if.outcome,
                                      want.outcome.name()));
            check_total("tp", rsp_if.tp_total, want.tp);
            check_total("fp", rsp_if.fp_total, want.fp);
            check_total("tn", rsp_if.tn_total, want.tn);
            check_total("fn", rsp_if.fn_total, want.fn);
         end
      end
   end

   // stimulus
   initial begin
      logic [THR_BITS-1:0] phase_thr [PHASES];
      int                  phase_send [PHASES];
      int                  phase_recv [PHASES];

      reset                    <= 1'b1;
      req_if.valid             <= 1'b0;
      req_if.truth_present     <= 1'b0;
      req_if.truth_x_min       <= '0;
      req_if.truth_y_min       <= '0;
      req_if.truth_x_max       <= '0;
      req_if.truth_y_max       <= '0;
      req_if.det_present       <= 1'b0;
      req_if.det_x_min         <= '0;
      req_if.det_y_min         <= '0;
      req_if.det_x_max         <= '0;
      req_if.det_y_max         <= '0;
      csr_if.valid             <= 1'b0;
      csr_if.overlap_threshold <= '0;
      long_hold_go             <= 1'b0;
      recv_stall_pct           <= 0;
      send_idle_pct = 0;
      errors        = 0;
      thr_writes    = 0;
      results_seen  = 0;
      model_thr     = THR_RESET;
      tp_count      = '0;
      fp_count      = '0;
      tn_count      = '0;
      fn_count      = '0;

      // directed pairs at the reset threshold of one half
      add_typed(boxes(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), totals(OUT_TN, 0, 0, 1, 0));
      add_typed(boxes(0, 65535, 65535, 65535, 65535, 1, 5, 5, 9, 9),
                totals(OUT_FP, 0, 1, 1, 0));
      add_typed(boxes(1, 5, 5, 9, 9, 0, 65535, 65535, 65535, 65535),
                totals(OUT_FN, 0, 1, 1, 1));
      add_typed(boxes(1, 0, 0, 65535, 65535, 1, 0, 0, 65535, 65535),
                totals(OUT_TP, 1, 1, 1, 1));
      // touching, disjoint, reversed truth edges
      add_typed(boxes(1, 0, 0, 10, 10, 1, 10, 0, 20, 10), totals(OUT_FP, 1, 2, 1, 1));
      add_typed(boxes(1, 0, 0, 10, 10, 1, 30, 30, 40, 40), totals(OUT_FP, 1, 3, 1, 1));
      add_typed(boxes(1, 20, 0, 10, 10, 1, 0, 0, 30, 10), totals(OUT_FP, 1, 4, 1, 1));
      // ratio exactly one half, then just under
      add_typed(boxes(1, 0, 0, 10, 10, 1, 0, 0, 20, 10), totals(OUT_TP, 2, 4, 1, 1));
      add_typed(boxes(1, 0, 0, 10, 10, 1, 0, 0, 21, 10), totals(OUT_FP, 2, 5, 1, 1));
      add_typed(boxes(1, 0, 0, 1, 1, 1, 0, 0, 1, 1), totals(OUT_TP, 3, 5, 1, 1));
      add_row(0, '0, boxes(1, 3, 7, 100, 90, 1, 50, 20, 200, 130));
      add_row(0, '0, boxes(1, 1000, 2000, 1500, 2600, 1, 1100, 2100, 1520, 2650));
      // zero threshold: any positive overlap passes
      add_row(1, '0, boxes(1, 0, 0, 2, 2, 1, 1, 1, 65535, 65535));
      add_row(0, '0, boxes(1, 0, 0, 10, 10, 1, 0, 10, 10, 20));
      // threshold of one and above
      add_row(1, THR_ONE, boxes(1, 100, 200, 300, 400, 1, 100, 200, 300, 400));
      add_row(0, '0, boxes(1, 100, 200, 300, 400, 1, 100, 200, 300, 401));
      add_row(1, THR_TOP, boxes(1, 100, 200, 300, 400, 1, 100, 200, 300, 400));
      add_row(0, '0, boxes(1, 0, 0, 65535, 65535, 1, 0, 0, 65535, 65535));
      add_row(1, THR_ONE + THR_BITS'(1), boxes(1, 7, 7, 9, 9, 1, 7, 7, 9, 9));
      // back to one half: zero-area boxes at the top corner, reversed detection edges
      add_row(1, THR_RESET, boxes(1, 65535, 65535, 65535, 65535, 1, 65535, 65535, 65535,
                                  65535));
      add_row(0, '0, boxes(1, 10, 10, 50, 50, 1, 20, 60, 40, 30));

      // random phases: threshold and idling per phase
      phase_thr[0] = THR_RESET;
      phase_thr[1] = '0;
      phase_thr[2] = THR_ONE;
      phase_thr[3] = THR_BITS'($urandom_range(65536));
      phase_thr[4] = THR_TOP;
      phase_thr[5] = THR_BITS'($urandom_range(131071));
      phase_send   = '{0, 71, 0, 14, 0, 71};
      phase_recv   = '{0, 0, 71, 14, 0, 71};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].set_thr)
            write_threshold(steps[i].thr);
         offer_pair(steps[i].pair, steps[i].typed, steps[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         write_threshold(phase_thr[ph]);
         send_idle_pct = phase_send[ph];
         recv_stall_pct <= phase_recv[ph];
         // first phase: long result hold-off while pairs keep coming
         if (ph == 0)
            long_hold_go <= 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n == PHASE_ITEMS / 2)
               settle();
            offer_pair(rand_pair(), 1'b0, totals(OUT_TN, 0, 0, 0, 0));
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("scored %0d box pairs: %0d tp, %0d fp, %0d tn, %0d fn",
               results_seen, tp_count, fp_count, tn_count, fn_count);
      $display("%0d threshold writes incl. 0, 1.0 and the 17-bit top; stalls and drains run",
               thr_writes);
      if (errors == 0)
         $display("tb_box_overlap_detection_scorer_top: clean");
      else
         $display("tb_box_overlap_detection_scorer_top: errors");
      $finish;
   end

endmodule
